// ===== rtl/core/b64d_pkg.sv =====
// Shared types, result codes and the character classifier for the base64 stream decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

    // Result kinds as seen on the output channel.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [15:0] MAX_OUT_LEN_RESET = 16'hFFFF;
    localparam int          QUEUE_DEPTH_DEF   = 4;

    typedef logic [5:0] t_sextet;

    // One decoded group: up to three data bytes, optionally followed by a status.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] n_data;
        logic       has_status;
        logic [1:0] status_kind;
    } t_job;

    // Map a character to {valid, sextet}; invalid characters map to zero.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] res;
        res = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            res = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            res = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            res = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            res = {1'b1, 6'd63};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// Front end: accepts characters, gathers groups of four and turns each finished group
// into one job record. Holds the capacity register and message state. Uses b64d_pkg.
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_end_of_text,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_max_out_len,
    input  logic              i_push_ready,
    output logic              o_push,
    output b64d_pkg::t_job    o_job
);
    import b64d_pkg::*;

    logic [15:0] r_max_out_len, n_max_out_len;
    t_sextet     r_sx [3];
    t_sextet     n_sx [3];
    logic [2:0]  r_mk, n_mk;
    logic [1:0]  r_pos, n_pos;
    logic [15:0] r_bw, n_bw;
    logic        r_failed, n_failed;

    logic [6:0]  cls;
    t_sextet     v;
    logic        ok;
    t_sextet     e_sx [3];
    logic [2:0]  e_mk;
    logic        ok3;
    logic        accept;
    logic        group_done;
    logic        cap_fail;
    logic        fail;
    logic [1:0]  n_data;

    assign o_in_ready  = i_push_ready;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign cls = sextet_of(i_in_char);
    assign v   = cls[5:0];
    assign ok  = cls[6];

    // Current character overlays its slot; later slots are still clear.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_sx[i] = (r_pos == 2'(i)) ? v  : r_sx[i];
            e_mk[i] = (r_pos == 2'(i)) ? ok : r_mk[i];
        end
    end

    assign ok3        = (r_pos == 2'd3) && ok;
    assign group_done = (r_pos == 2'd3) || i_end_of_text;
    assign cap_fail   = ({1'b0, r_bw} + 17'd3) >= {1'b0, r_max_out_len};
    assign fail       = cap_fail || !e_mk[0] || !e_mk[1];
    assign n_data     = fail ? 2'd0 : (e_mk[2] ? (ok3 ? 2'd3 : 2'd2) : 2'd1);

    always_comb begin
        o_job.byte0       = {e_sx[0], e_sx[1][5:4]};
        o_job.byte1       = {e_sx[1][3:0], e_sx[2][5:2]};
        o_job.byte2       = {e_sx[2][1:0], v};
        o_job.n_data      = n_data;
        o_job.has_status  = fail || i_end_of_text;
        o_job.status_kind = fail ? KIND_FAIL : KIND_OK;
    end

    assign o_push = accept && !r_failed && group_done;

    always_comb begin
        n_max_out_len = r_max_out_len;
        n_sx          = r_sx;
        n_mk          = r_mk;
        n_pos         = r_pos;
        n_bw          = r_bw;
        n_failed      = r_failed;
        if (i_cfg_valid) begin
            n_max_out_len = i_cfg_max_out_len;
        end
        if (accept) begin
            if (r_failed) begin
                // drop characters until the end of the failed message
                if (i_end_of_text) begin
                    n_sx     = '{default: '0};
                    n_mk     = 3'd0;
                    n_pos    = 2'd0;
                    n_bw     = 16'd0;
                    n_failed = 1'b0;
                end
            end else if (group_done) begin
                n_sx  = '{default: '0};
                n_mk  = 3'd0;
                n_pos = 2'd0;
                if (i_end_of_text) begin
                    n_bw     = 16'd0;
                    n_failed = 1'b0;
                end else if (fail) begin
                    n_failed = 1'b1;
                end else begin
                    n_bw = r_bw + 16'(n_data);
                end
            end else begin
                n_sx[r_pos] = v;
                n_mk[r_pos] = ok;
                n_pos       = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out_len <= MAX_OUT_LEN_RESET;
            r_sx          <= '{default: '0};
            r_mk          <= 3'd0;
            r_pos         <= 2'd0;
            r_bw          <= 16'd0;
            r_failed      <= 1'b0;
        end else begin
            r_max_out_len <= n_max_out_len;
            r_sx          <= n_sx;
            r_mk          <= n_mk;
            r_pos         <= n_pos;
            r_bw          <= n_bw;
            r_failed      <= n_failed;
        end
    end

endmodule

// ===== rtl/core/b64d_queue.sv =====
// Short job queue between the front and back ends of the decoder.
// Register-based ring with a fill count. Uses b64d_pkg.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_job    i_job,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_nonempty,
    output b64d_pkg::t_job    o_head
);
    import b64d_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_nonempty   = (r_count != '0);
    assign o_head       = r_mem[r_head];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_nonempty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == IW'(DEPTH - 1)) ? '0 : r_tail + IW'(1);
        end
        if (do_pop) begin
            n_head = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/b64d_back.sv =====
// Back end: expands the job at the head of the queue into result items, one per cycle
// while the output is ready, through a single output register. Uses b64d_pkg.
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  b64d_pkg::t_job    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_kind,
    output logic              o_last
);
    import b64d_pkg::*;

    logic [1:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic [1:0] r_kind, n_kind;
    logic       r_last, n_last;

    logic       load;
    logic [2:0] total;
    logic       final_step;
    logic [7:0] sel_byte;
    logic [1:0] sel_kind;

    assign load       = i_nonempty && (!r_valid || i_out_ready);
    assign total      = {1'b0, i_head.n_data} + {2'b00, i_head.has_status};
    assign final_step = ({1'b0, r_step} + 3'd1) == total;
    assign o_pop      = load && final_step;

    always_comb begin
        if (r_step < i_head.n_data) begin
            case (r_step)
                2'd0:    sel_byte = i_head.byte0;
                2'd1:    sel_byte = i_head.byte1;
                default: sel_byte = i_head.byte2;
            endcase
            sel_kind = KIND_DATA;
        end else begin
            sel_byte = 8'd0;
            sel_kind = i_head.status_kind;
        end
    end

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_kind  = r_kind;
        n_last  = r_last;
        if (load) begin
            n_valid = 1'b1;
            n_byte  = sel_byte;
            n_kind  = sel_kind;
            n_last  = final_step;
            n_step  = final_step ? 2'd0 : r_step + 2'd1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_kind <= n_kind;
        r_last <= n_last;
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

endmodule

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Base64 stream decoder: one character per cycle in while the queue has room, one result
// item per cycle out while the output is ready. A group's first result passes through
// the queue write and then the back end output register after its closing character.
// Throughput: 1 character per cycle; the back end issues 1 result per cycle, so the
// job queue (QUEUE_DEPTH groups) only fills when the output side stalls.
// Reset (synchronous, active low) clears message state, queue and output; the
// capacity register returns to 65535.
module base64_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_end_of_text,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic        o_last,
    // capacity register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_out_len
);
    import b64d_pkg::*;

    // Front to queue: one job per finished group (or per failing / final group).
    logic  push;
    logic  push_ready;
    t_job  job;

    // Queue to back end.
    logic  pop;
    logic  nonempty;
    t_job  head;

    // Classify characters, track group and message state, and hold the capacity
    // register. Stall input only when the queue is full.
    b64d_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_char         (i_in_char),
        .i_end_of_text     (i_end_of_text),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_max_out_len (i_cfg_max_out_len),
        .i_push_ready      (push_ready),
        .o_push            (push),
        .o_job             (job)
    );

    // Decouple the two sides so a stalled output does not block character intake.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_nonempty   (nonempty),
        .o_head       (head)
    );

    // One result per cycle from the head job unless stalled; pop it with its last result.
    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/core/b64d_checker.sv =====
// Port-level checks for the base64 stream decoder, bound to its top level.
// Uses b64d_pkg for the result kind codes.
module b64d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_kind,
    input logic        o_last
);
    import b64d_pkg::*;

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // A status result closes the item's run and carries a zero byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_OK || o_kind == KIND_FAIL)
            |-> o_last && (o_out_byte == 8'd0))
        else $error("status result not last or nonzero byte");

    // Only defined kinds appear.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_DATA || o_kind == KIND_OK || o_kind == KIND_FAIL))
        else $error("undefined result kind");

    // Drop any pending result at reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_kind      (o_kind),
    .o_last      (o_last)
);

// ===== bench/base64_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_decoder_unit: directed and random character
// streams, each result item checked in order against a bit-accurate decoder model.
// Depends on b64d_pkg and the decoder RTL.
module base64_stream_decoder_unit_tb;
    import b64d_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int IDLE_PCT_DEF   = 29;
    localparam int MAX_GAP        = 12;
    localparam int PHASE_ITEMS    = 32;
    localparam int NUM_PHASES     = 6;
    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '=' is never part of the alphabet

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    ok;
        t_sextet val;
    } t_sym;

    // Every input starts at a known value.
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic [7:0]  i_in_char         = 8'h00;
    logic        i_end_of_text     = 1'b0;
    logic        i_out_ready       = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [15:0] i_cfg_max_out_len = 16'h0000;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic        o_last;
    logic        o_cfg_ready;

    base64_stream_decoder_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_char         (i_in_char),
        .i_end_of_text     (i_end_of_text),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_kind            (o_kind),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_max_out_len (i_cfg_max_out_len)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Decoded results still owed by the block, oldest first.
    t_result     pending_results[$];
    int          error_count = 0;
    int          idle_pct    = IDLE_PCT_DEF;
    int          live_items  = 0;   // items accepted by the decoder, swallowed ones too

    // Decoder model state, mirrored from the block.
    t_sextet     grp_sx[3];
    logic [2:0]  grp_ok;
    logic [1:0]  grp_pos;
    logic [15:0] msg_bytes;
    logic        msg_failed;
    logic [15:0] cap_limit;

    // Classify one raw code; anything off the standard alphabet is invalid.
    function automatic t_sym char_to_sym(input logic [7:0] c);
        t_sym s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.ok = 1'b1; s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.ok = 1'b1; s.val = 6'(c - 8'h47);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.ok = 1'b1; s.val = 6'(c + 8'h04);
        end else if (c == 8'h2B) begin
            s.ok = 1'b1; s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.ok = 1'b1; s.val = 6'd63;
        end
        return s;
    endfunction

    // Map a sextet value back to its alphabet character.
    function automatic logic [7:0] b64_char(input int unsigned idx);
        if (idx < 26) return 8'(8'h41 + idx);
        if (idx < 52) return 8'(8'h61 + idx - 26);
        if (idx < 62) return 8'(8'h30 + idx - 52);
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    // Mostly alphabet characters, now and then any byte at all.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 92) return b64_char($urandom_range(63));
        return 8'($urandom_range(255));
    endfunction

    function automatic void clear_group();
        grp_sx[0] = '0;
        grp_sx[1] = '0;
        grp_sx[2] = '0;
        grp_ok    = '0;
        grp_pos   = '0;
    endfunction

    function automatic void clear_message();
        clear_group();
        msg_bytes  = '0;
        msg_failed = 1'b0;
    endfunction

    // Advance the decoder model by one accepted character and queue what it emits.
    task automatic decode_char(input logic [7:0] c, input logic eot);
        t_sym       sym;
        t_sextet    s3;
        logic       ok3;
        logic [1:0] pos;
        int         n_data;
        logic [7:0] dec_bytes[3];
        s3  = '0;
        ok3 = 1'b0;
        live_items++;
        // Swallow everything after a failure; the final character reopens the stream.
        if (msg_failed) begin
            if (eot) clear_message();
            return;
        end
        sym = char_to_sym(c);
        pos = grp_pos;
        if (pos != 2'd3) begin
            grp_sx[pos] = sym.val;
            if (sym.ok) grp_ok[pos] = 1'b1;
        end else begin
            s3  = sym.val;
            ok3 = sym.ok;
        end
        // Hold a partial group until it closes or the message ends.
        if (pos != 2'd3 && !eot) begin
            grp_pos = pos + 2'd1;
            return;
        end
        if ({1'b0, msg_bytes} + 17'd3 >= {1'b0, cap_limit} || !grp_ok[0] || !grp_ok[1]) begin
            pending_results.push_back('{8'h00, KIND_FAIL, 1'b1});
            if (eot) begin
                clear_message();
            end else begin
                clear_group();
                msg_failed = 1'b1;
            end
            return;
        end
        dec_bytes[0] = {grp_sx[0], grp_sx[1][5:4]};
        dec_bytes[1] = {grp_sx[1][3:0], grp_sx[2][5:2]};
        dec_bytes[2] = {grp_sx[2][1:0], s3};
        n_data = grp_ok[2] ? (ok3 ? 3 : 2) : 1;
        for (int i = 0; i < n_data; i++) begin
            pending_results.push_back('{dec_bytes[i], KIND_DATA, (i == n_data - 1) && !eot});
        end
        msg_bytes = msg_bytes + 16'(n_data);
        clear_group();
        if (eot) begin
            pending_results.push_back('{8'h00, KIND_OK, 1'b1});
            clear_message();
        end
    endtask

    // Send one character item. Valid stays high on return so a back-to-back item
    // needs no second assignment in the same step.
    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_char     <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        decode_char(c, eot);
    endtask

    task automatic send_text(input string s, input logic eot_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eot_at_end && (i == s.len() - 1));
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register, only once the block has gone idle.
    task automatic write_cap(input logic [15:0] val);
        wait_drained();
        i_cfg_valid       <= 1'b1;
        i_cfg_max_out_len <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_limit = val;
    endtask

    // Alphabet extremes, padded and short final groups, invalid leads, high codes.
    task automatic test_directed();
        send_text("QUJD", 1'b0);      // plain full group
        send_text("+/09", 1'b0);      // top of the alphabet
        send_text("AZaz", 1'b0);      // letter range edges
        send_text("Tw", 1'b1);        // message ends two characters into a group
        send_text("TWE=", 1'b1);      // invalid fourth: two bytes
        send_text("T", 1'b1);         // lone final character: second one missing
        send_text("=AAAA", 1'b1);     // invalid lead fails, rest swallowed to the end
        send_char(8'h80, 1'b0);       // high codes and control codes are invalid
        send_char(8'h00, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // Capacity limits: zero, just below one group, a couple of groups, and the top.
    task automatic test_capacity();
        write_cap(16'h0000);
        send_text("AAAA", 1'b1);
        write_cap(16'd3);
        send_text("QQ", 1'b1);
        write_cap(16'd7);
        send_text("QUJDQUJDQQ", 1'b1);   // third group hits the limit
        write_cap(16'hFFFF);
        send_text("QUJD", 1'b1);
    endtask

    // Phases of mostly well-formed messages with random content, plus raw noise.
    task automatic test_random_messages();
        int start_live;
        int len;
        int pads;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1, 4: begin
                    write_cap(16'($urandom_range(30)));
                end
                3: begin
                    write_cap(16'($urandom_range(65535)));
                end
                default: begin
                    write_cap(16'hFFFF);
                end
            endcase
            // One phase runs with no idling on either side.
            idle_pct   = (phase == 2) ? 0 : IDLE_PCT_DEF;
            start_live = live_items;
            while (live_items - start_live < PHASE_ITEMS) begin
                if ($urandom_range(99) < 8) begin
                    send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
                end else begin
                    len  = $urandom_range(13, 1);
                    pads = $urandom_range(2);
                    for (int i = 0; i < len + pads; i++) begin
                        send_char((i >= len) ? PAD_CHAR : pick_char(), i == len + pads - 1);
                    end
                end
            end
        end
        idle_pct = IDLE_PCT_DEF;
    endtask

    // Check each result item against the oldest owed one; randomize ready.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result byte=%h kind=%0d last=%0b",
                         $time, o_out_byte, o_kind, o_last);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, o_out_byte);
                    error_count++;
                end
                if (o_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, o_kind);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // End the run if no item moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog: no item moved in %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        clear_message();
        cap_limit = MAX_OUT_LEN_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random_messages();
        // Drain, then watch a while longer for stray results.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
